[src/owm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_pkg
// shared types, register map and defaults of the single-wire bus master
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 10;
    localparam int BITS_PER_BYTE        = 8;
    localparam int CFG_W                = 10;
    localparam int CFG_ADDR_W           = 5;
    localparam int APB_DATA_W           = 32;
    localparam int BIT_LEFT_W           = 4;

    // register indexes
    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] REG_RESET_RECOVER = 3'd2;
    localparam logic [2:0] REG_START_LOW     = 3'd3;
    localparam logic [2:0] REG_WRITE_SLOT    = 3'd4;
    localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
    localparam logic [2:0] REG_READ_RECOVER  = 3'd6;

    // reset values
    localparam logic [CFG_W-1:0] RESET_LOW_DEF     = 10'd483;
    localparam logic [CFG_W-1:0] PRESENCE_WAIT_DEF = 10'd75;
    localparam logic [CFG_W-1:0] RESET_RECOVER_DEF = 10'd411;
    localparam logic [CFG_W-1:0] START_LOW_DEF     = 10'd2;
    localparam logic [CFG_W-1:0] WRITE_SLOT_DEF    = 10'd67;
    localparam logic [CFG_W-1:0] READ_SAMPLE_DEF   = 10'd19;
    localparam logic [CFG_W-1:0] READ_RECOVER_DEF  = 10'd19;

    typedef enum logic [1:0] {
        ACT_RESET = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_RST_LOW     = 4'd1,
        PH_RST_WAIT    = 4'd2,
        PH_RST_RECOVER = 4'd3,
        PH_WR_START    = 4'd4,
        PH_WR_HOLD     = 4'd5,
        PH_RD_START    = 4'd6,
        PH_RD_WAIT     = 4'd7,
        PH_RD_RECOVER  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_ticks;
        logic [CFG_W-1:0] presence_wait_ticks;
        logic [CFG_W-1:0] reset_recover_ticks;
        logic [CFG_W-1:0] start_low_ticks;
        logic [CFG_W-1:0] write_slot_ticks;
        logic [CFG_W-1:0] read_sample_ticks;
        logic [CFG_W-1:0] read_recover_ticks;
    } cfg_t;

    typedef struct packed {
        logic       start_req;
        logic [1:0] action;
        logic [7:0] write_byte;
        logic       line_in;
    } item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
    } res_t;

endpackage

[src/owm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_tick_if / owm_status_if
// valid/ready channels for bus ticks and status results
// ----------------------------------------------------------------------------
interface owm_tick_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [1:0] action;
    logic [7:0] write_byte;
    logic       line_in;

    modport source (output valid, start_req, action, write_byte, line_in, input ready);
    modport sink   (input valid, start_req, action, write_byte, line_in, output ready);
endinterface

interface owm_status_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;

    modport source (output valid, drive_low, busy_res, done_res, read_byte, input ready);
    modport sink   (input valid, drive_low, busy_res, done_res, read_byte, output ready);
endinterface

[src/owm_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_cfg
// apb register file holding the seven slot timing registers
// ----------------------------------------------------------------------------
module owm_cfg
    import owm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             wr_en;
    logic [2:0]       reg_idx;
    logic [CFG_W-1:0] wdata;
    logic [CFG_W-1:0] rdata;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign wdata   = pwdata[CFG_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_RESET_LOW:     cfg_next.reset_low_ticks     = wdata;
                REG_PRESENCE_WAIT: cfg_next.presence_wait_ticks = wdata;
                REG_RESET_RECOVER: cfg_next.reset_recover_ticks = wdata;
                REG_START_LOW:     cfg_next.start_low_ticks     = wdata;
                REG_WRITE_SLOT:    cfg_next.write_slot_ticks    = wdata;
                REG_READ_SAMPLE:   cfg_next.read_sample_ticks   = wdata;
                REG_READ_RECOVER:  cfg_next.read_recover_ticks  = wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RESET_LOW:     rdata = cfg_reg.reset_low_ticks;
            REG_PRESENCE_WAIT: rdata = cfg_reg.presence_wait_ticks;
            REG_RESET_RECOVER: rdata = cfg_reg.reset_recover_ticks;
            REG_START_LOW:     rdata = cfg_reg.start_low_ticks;
            REG_WRITE_SLOT:    rdata = cfg_reg.write_slot_ticks;
            REG_READ_SAMPLE:   rdata = cfg_reg.read_sample_ticks;
            REG_READ_RECOVER:  rdata = cfg_reg.read_recover_ticks;
            default:           rdata = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(rdata);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks     <= RESET_LOW_DEF;
            cfg_reg.presence_wait_ticks <= PRESENCE_WAIT_DEF;
            cfg_reg.reset_recover_ticks <= RESET_RECOVER_DEF;
            cfg_reg.start_low_ticks     <= START_LOW_DEF;
            cfg_reg.write_slot_ticks    <= WRITE_SLOT_DEF;
            cfg_reg.read_sample_ticks   <= READ_SAMPLE_DEF;
            cfg_reg.read_recover_ticks  <= READ_RECOVER_DEF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/owm_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_engine
// phase sequencer: one tick per step, tick counter, bit shifter, read holder
// ----------------------------------------------------------------------------
module owm_engine
    import owm_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    localparam int TCW  = TICK_COUNT_WIDTH;
    localparam int CMPW = (TCW > CFG_W) ? TCW : CFG_W;
    localparam logic [TCW-1:0] TC_MAX = {TCW{1'b1}};
    localparam logic [TCW-1:0] TC_ONE = TCW'(1);

    phase_t                phase_reg,   phase_next;
    logic [TCW-1:0]        tc_reg,      tc_next;
    logic [BIT_LEFT_W-1:0] bit_left_reg, bit_left_next;
    logic [7:0]            shift_reg,   shift_next;
    action_t               action_reg,  action_next;
    logic [7:0]            hold_reg,    hold_next;
    logic                  done;
    logic [CFG_W-1:0]      len;
    logic                  expired;
    logic [BIT_LEFT_W-1:0] bit_left_dec;

    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:     len = cfg.reset_low_ticks;
            PH_RST_WAIT:    len = cfg.presence_wait_ticks;
            PH_RST_RECOVER: len = cfg.reset_recover_ticks;
            PH_WR_START:    len = cfg.start_low_ticks;
            PH_RD_START:    len = cfg.start_low_ticks;
            PH_WR_HOLD:     len = cfg.write_slot_ticks;
            PH_RD_WAIT:     len = cfg.read_sample_ticks;
            PH_RD_RECOVER:  len = cfg.read_recover_ticks;
            default:        len = CFG_W'(1);
        endcase
    end

    assign expired      = (CMPW'(tc_reg) >= CMPW'(len)) || (tc_reg == TC_MAX);
    assign bit_left_dec = bit_left_reg - BIT_LEFT_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        tc_next       = tc_reg;
        bit_left_next = bit_left_reg;
        shift_next    = shift_reg;
        action_next   = action_reg;
        hold_next     = hold_reg;
        done          = 1'b0;

        case (phase_reg)
            PH_RST_LOW, PH_RST_WAIT, PH_RST_RECOVER, PH_WR_START,
            PH_WR_HOLD, PH_RD_START, PH_RD_WAIT, PH_RD_RECOVER:
            begin
                if (!expired)
                begin
                    tc_next = tc_reg + TC_ONE;
                end
                else
                begin
                    tc_next = TC_ONE;
                    case (phase_reg)
                        PH_RST_LOW:  phase_next = PH_RST_WAIT;
                        PH_RST_WAIT: phase_next = item.line_in ? PH_RST_LOW : PH_RST_RECOVER;
                        PH_WR_START: phase_next = PH_WR_HOLD;
                        PH_WR_HOLD:
                        begin
                            shift_next    = {1'b0, shift_reg[7:1]};
                            bit_left_next = bit_left_dec;
                            phase_next    = PH_WR_START;
                            if (bit_left_dec == '0)
                            begin
                                phase_next = PH_IDLE;
                                tc_next    = '0;
                                done       = 1'b1;
                            end
                        end
                        PH_RD_START: phase_next = PH_RD_WAIT;
                        PH_RD_WAIT:
                        begin
                            shift_next = {item.line_in, shift_reg[7:1]};
                            phase_next = PH_RD_RECOVER;
                        end
                        PH_RD_RECOVER:
                        begin
                            bit_left_next = bit_left_dec;
                            phase_next    = PH_RD_START;
                            if (bit_left_dec == '0)
                            begin
                                hold_next  = shift_reg;
                                phase_next = PH_IDLE;
                                tc_next    = '0;
                                done       = 1'b1;
                            end
                        end
                        default:
                        begin
                            // reset recovery over
                            phase_next = PH_IDLE;
                            tc_next    = '0;
                            done       = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (item.start_req)
                begin
                    case (item.action)
                        ACT_RESET:
                        begin
                            action_next   = ACT_RESET;
                            bit_left_next = BIT_LEFT_W'(BITS_PER_BYTE);
                            shift_next    = '0;
                            phase_next    = PH_RST_LOW;
                            tc_next       = TC_ONE;
                        end
                        ACT_WRITE:
                        begin
                            action_next   = ACT_WRITE;
                            bit_left_next = BIT_LEFT_W'(BITS_PER_BYTE);
                            shift_next    = item.write_byte;
                            phase_next    = PH_WR_START;
                            tc_next       = TC_ONE;
                        end
                        ACT_READ:
                        begin
                            action_next   = ACT_READ;
                            bit_left_next = BIT_LEFT_W'(BITS_PER_BYTE);
                            shift_next    = '0;
                            phase_next    = PH_RD_START;
                            tc_next       = TC_ONE;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        case (phase_next)
            PH_RST_LOW, PH_WR_START, PH_RD_START: res.drive_low = 1'b1;
            PH_WR_HOLD:                           res.drive_low = ~shift_next[0];
            default:                              res.drive_low = 1'b0;
        endcase
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done;
        res.read_byte = hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tc_reg       <= '0;
            bit_left_reg <= '0;
            shift_reg    <= '0;
            action_reg   <= ACT_RESET;
            hold_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tc_reg       <= tc_next;
            bit_left_reg <= bit_left_next;
            shift_reg    <= shift_next;
            action_reg   <= action_next;
            hold_reg     <= hold_next;
        end
    end

    a_write_phase_action : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WR_START || phase_reg == PH_WR_HOLD) |-> action_reg == ACT_WRITE)
        else $error("write slot running without a latched write command");

    a_busy_count_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> tc_reg != '0)
        else $error("tick counter zero inside a timed phase");

    a_bit_left_range : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (bit_left_reg != '0 &&
                                    bit_left_reg <= BIT_LEFT_W'(BITS_PER_BYTE)))
        else $error("bit counter out of range during a command");

    a_done_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (step && done) |=> phase_reg == PH_IDLE)
        else $error("sequencer not idle after finishing a command");

    a_hold_without_step : assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_reg) && $stable(tc_reg) && $stable(hold_reg)))
        else $error("sequencer state moved without a tick");

endmodule

[src/one_wire_bus_master_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_core
// single-wire bus master: one tick transfer in, one status transfer out
//
//   channel   dir  handshake        payload
//   tick      in   valid / ready    start_req, action, write_byte, line_in
//   status    out  valid / ready    drive_low, busy_res, done_res, read_byte
//   apb       in   psel / penable   paddr, pwdata, prdata (pready tied high)
//
// one tick per clock unless status stalls; tick -> input reg -> status reg
// the sequencer step (phase, counter, shifter) is one registered pass
// reset clears control state and loads the timing register defaults
// a stalled status holds; the input register absorbs one more tick
// ----------------------------------------------------------------------------
module one_wire_bus_master_core
    import owm_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    owm_tick_if.sink              tick,
    owm_status_if.source          status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t  cfg;
    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg;
    logic  out_valid_reg, out_valid_next;
    res_t  out_res_reg;
    res_t  res;
    logic  step;
    logic  take;

    owm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owm_engine #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign step       = in_valid_reg && (!out_valid_reg || status.ready);
    assign tick.ready = !in_valid_reg || step;
    assign take       = tick.valid && tick.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg.start_req  <= tick.start_req;
            in_item_reg.action     <= tick.action;
            in_item_reg.write_byte <= tick.write_byte;
            in_item_reg.line_in    <= tick.line_in;
        end
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    assign status.valid     = out_valid_reg;
    assign status.drive_low = out_res_reg.drive_low;
    assign status.busy_res  = out_res_reg.busy_res;
    assign status.done_res  = out_res_reg.done_res;
    assign status.read_byte = out_res_reg.read_byte;

endmodule
